// ----- rtl/rcc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rcc_pkg;

	// field widths of one item and of one slot entry
	localparam int FS_W   = 8;
	localparam int OBJ_W  = 32;
	localparam int CNT_W  = 16;
	localparam int SLOT_W = 6;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_HIT          = 3'd0,
		ST_LOAD         = 3'd1,
		ST_FULL         = 3'd2,
		ST_BADFS        = 3'd3,
		ST_HELD         = 3'd4,
		ST_FREED        = 3'd5,
		ST_ALREADY_FREE = 3'd6,
		ST_SATURATED    = 3'd7
	} status_t;

	typedef struct packed {
		logic [FS_W-1:0]  fs;
		logic [OBJ_W-1:0] obj;
		logic [CNT_W-1:0] cnt;
	} entry_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_PUT_RD,
		S_UPDATE
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic clear_wr;
		logic capture;
		logic scan_start;
		logic scan_step;
		logic put_rd;
		logic commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic is_put;
		logic bad_fs;
		logic hit_now;
		logic scan_last;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

// ----- rtl/refcounted_object_cache_top.sv -----
// Reference-counted object cache of SLOTS slots kept in one RAM. A get walks the slots in order,
// looking for a slot with the same filesystem id and object number while noting the lowest free
// slot, and stops early on a hit; a get with filesystem id zero is rejected without a walk.
// A put reads its one slot. The walk reads one slot per cycle through the RAM read port.
// After reset the block clears the RAM in one pass before it takes its first item. One item is in
// work at a time; its result sits in an output register, so the next item is taken while it waits.
`timescale 1ns / 1ps
`default_nettype none

module refcounted_object_cache_top #(
	parameter int SLOTS = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       opcode,
	input  logic [rcc_pkg::FS_W-1:0]   fs_id,
	input  logic [rcc_pkg::OBJ_W-1:0]  object_number,
	input  logic [rcc_pkg::SLOT_W-1:0] slot_index,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [2:0]                 status,
	output logic [rcc_pkg::SLOT_W-1:0] result_slot,
	output logic [rcc_pkg::CNT_W-1:0]  ref_count
);

	import rcc_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	rcc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	rcc_datapath #(
		.SLOTS(SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.opcode       (opcode),
		.fs_id        (fs_id),
		.object_number(object_number),
		.slot_index   (slot_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.result_slot  (result_slot),
		.ref_count    (ref_count)
	);

	// a result never overwrites one still waiting
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid || out_ready))
		else $error("result loaded over a waiting result");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("item accepted while another is in work");

	// a fresh claim always carries a count of one
	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == 3'(ST_LOAD)) |-> (ref_count == CNT_W'(1)))
		else $error("claimed slot with count other than one");

	// full and rejected gets name no slot
	a_none_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == 3'(ST_FULL) || status == 3'(ST_BADFS)))
		|-> (result_slot == '0 && ref_count == '0))
		else $error("slot reported for full or rejected get");

endmodule

`default_nettype wire

// ----- rtl/rcc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rcc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rcc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rcc_pkg::stat_t stat,
	output rcc_pkg::cmd_t  cmd
);

	import rcc_pkg::*;

	ctrl_state_t state_q, state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_CLEAR: begin
				if (stat.clr_last) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_nxt = S_DISPATCH;
			end
			S_DISPATCH: begin
				if (stat.is_put) state_nxt = S_PUT_RD;
				else if (stat.bad_fs) state_nxt = S_UPDATE;
				else state_nxt = S_SCAN;
			end
			S_SCAN: begin
				if (stat.hit_now || stat.scan_last) state_nxt = S_UPDATE;
			end
			S_PUT_RD: begin
				state_nxt = S_UPDATE;
			end
			S_UPDATE: begin
				if (stat.out_free) state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_CLEAR;
			end
		endcase
	end

	// command outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear_wr = 1'b1;
			end
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_DISPATCH: begin
				cmd.scan_start = !stat.is_put && !stat.bad_fs;
			end
			S_SCAN: begin
				cmd.scan_step = !(stat.hit_now || stat.scan_last);
			end
			S_PUT_RD: begin
				cmd.put_rd = 1'b1;
			end
			S_UPDATE: begin
				cmd.commit = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/rcc_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rcc_datapath #(
	parameter int SLOTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rcc_pkg::cmd_t                 cmd,
	output rcc_pkg::stat_t                stat,
	input  logic                          opcode,
	input  logic [rcc_pkg::FS_W-1:0]      fs_id,
	input  logic [rcc_pkg::OBJ_W-1:0]     object_number,
	input  logic [rcc_pkg::SLOT_W-1:0]    slot_index,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    status,
	output logic [rcc_pkg::SLOT_W-1:0]    result_slot,
	output logic [rcc_pkg::CNT_W-1:0]     ref_count
);

	import rcc_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int EW = $bits(entry_t);

	// captured item
	logic              op_q;
	logic [FS_W-1:0]   fs_q;
	logic [OBJ_W-1:0]  obj_q;
	logic [SLOT_W-1:0] idx_q;

	// scan bookkeeping
	logic [IW:0]       iss_q;
	logic [IW-1:0]     clr_q;
	logic [IW-1:0]     rd_tag_s1;
	logic              rd_vld_s1;
	logic              hit_q;
	logic [IW-1:0]     hit_idx_q;
	logic [CNT_W-1:0]  hit_cnt_q;
	logic              free_q;
	logic [IW-1:0]     free_idx_q;

	// ram ports
	logic              ram_we, ram_re;
	logic [IW-1:0]     ram_waddr, ram_raddr;
	entry_t            ram_wdata, ram_rdata;
	logic [EW-1:0]     ram_rdata_raw;

	// update results
	logic              upd_we;
	logic [IW-1:0]     upd_addr;
	entry_t            upd_data;
	status_t           res_status;
	logic [SLOT_W-1:0] res_slot;
	logic [CNT_W-1:0]  res_cnt;

	logic              issue;
	logic              match;
	logic              in_range;
	logic [CNT_W-1:0]  put_cnt;

	assign ram_rdata = entry_t'(ram_rdata_raw);
	assign issue     = cmd.scan_step && (iss_q < (IW+1)'(SLOTS));
	assign match     = (ram_rdata.fs == fs_q) && (ram_rdata.obj == obj_q);
	assign in_range  = 32'(idx_q) < 32'(SLOTS);
	assign put_cnt   = ram_rdata.cnt - 1'b1;

	// status toward the controller
	always_comb begin
		stat           = '0;
		stat.clr_last  = clr_q == IW'(SLOTS - 1);
		stat.is_put    = op_q == OP_PUT;
		stat.bad_fs    = fs_q == '0;
		stat.hit_now   = rd_vld_s1 && match;
		stat.scan_last = rd_vld_s1 && (rd_tag_s1 == IW'(SLOTS - 1));
		stat.out_free  = !out_valid || out_ready;
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= opcode;
			fs_q  <= fs_id;
			obj_q <= object_number;
			idx_q <= slot_index;
		end
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// scan: issue reads, compare on the registered read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q     <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (cmd.scan_start) begin
				iss_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else begin
				if (issue) iss_q <= iss_q + 1'b1;
				if (rd_vld_s1 && match && !hit_q) hit_q <= 1'b1;
				if (rd_vld_s1 && (ram_rdata.cnt == '0) && !free_q) free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) rd_tag_s1 <= iss_q[IW-1:0];
		if (rd_vld_s1 && match && !hit_q) begin
			hit_idx_q <= rd_tag_s1;
			hit_cnt_q <= ram_rdata.cnt;
		end
		if (rd_vld_s1 && (ram_rdata.cnt == '0) && !free_q) begin
			free_idx_q <= rd_tag_s1;
		end
	end

	// outcome of the item and the entry to write back
	always_comb begin
		upd_we     = 1'b0;
		upd_addr   = hit_idx_q;
		upd_data   = '0;
		res_status = ST_FULL;
		res_slot   = '0;
		res_cnt    = '0;
		if (op_q == OP_GET) begin
			if (fs_q == '0) begin
				res_status = ST_BADFS;
			end else if (hit_q) begin
				res_slot = SLOT_W'(hit_idx_q);
				if (hit_cnt_q == COUNT_MAX) begin
					res_status = ST_SATURATED;
					res_cnt    = hit_cnt_q;
				end else begin
					res_status   = ST_HIT;
					res_cnt      = hit_cnt_q + 1'b1;
					upd_we       = 1'b1;
					upd_data.fs  = fs_q;
					upd_data.obj = obj_q;
					upd_data.cnt = hit_cnt_q + 1'b1;
				end
			end else if (free_q) begin
				res_status   = ST_LOAD;
				res_slot     = SLOT_W'(free_idx_q);
				res_cnt      = CNT_W'(1);
				upd_we       = 1'b1;
				upd_addr     = free_idx_q;
				upd_data.fs  = fs_q;
				upd_data.obj = obj_q;
				upd_data.cnt = CNT_W'(1);
			end
		end else begin
			res_slot = idx_q;
			upd_addr = IW'(idx_q);
			if (!in_range || (ram_rdata.cnt == '0)) begin
				res_status = ST_ALREADY_FREE;
			end else if (put_cnt == '0) begin
				res_status = ST_FREED;
				upd_we     = 1'b1;
			end else begin
				res_status   = ST_HELD;
				res_cnt      = put_cnt;
				upd_we       = 1'b1;
				upd_data.fs  = ram_rdata.fs;
				upd_data.obj = ram_rdata.obj;
				upd_data.cnt = put_cnt;
			end
		end
	end

	// ram port selection
	always_comb begin
		ram_we    = cmd.clear_wr || (cmd.commit && upd_we);
		ram_waddr = cmd.clear_wr ? clr_q : upd_addr;
		ram_wdata = cmd.clear_wr ? entry_t'('0) : upd_data;
		ram_re    = issue || cmd.put_rd;
		ram_raddr = cmd.put_rd ? IW'(idx_q) : iss_q[IW-1:0];
	end

	rcc_ram #(
		.WIDTH(EW),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(EW'(ram_wdata)),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata_raw)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.commit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status      <= 3'(res_status);
			result_slot <= res_slot;
			ref_count   <= res_cnt;
		end
	end

endmodule

`default_nettype wire
